@@ rtl/assert_macros.svh @@
// Assertion helpers for the frame handler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PCFH_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define PCFH_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define PCFH_ASSERT(lbl, clk, rstn, prop, msg)

`define PCFH_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

@@ rtl/pcfh_pkg.sv @@
package pcfh_pkg;

  localparam logic [7:0] SOF_BYTE       = 8'hAA;
  localparam logic [7:0] BCAST_ADDR     = 8'hFF;
  localparam logic [7:0] CMD_ACK        = 8'hE0;
  localparam logic [7:0] CMD_READ       = 8'hE1;
  localparam logic [7:0] CMD_WRITE      = 8'hE2;
  localparam logic [7:0] SYS_RST_CODE   = 8'h02;
  localparam logic [7:0] ACK_TYPE       = 8'h00;
  localparam logic [7:0] ACK_PAY_LEN    = 8'h03;
  localparam logic [7:0] PARAM_PAY_LEN  = 8'h06;
  localparam logic [7:0] DEV_ADDR_RST   = 8'h05;
  localparam int         ID_W           = 16;
  localparam int         FIELD_BYTES    = 6;
  localparam int         FRAME_BYTES    = 10;
  localparam logic [3:0] ACK_FRAME_LEN  = 4'd7;
  localparam logic [3:0] PRM_FRAME_LEN  = 4'd10;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_CHECK,
    ST_PREAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic rx_we;
    logic clr_en;
    logic walk_start;
    logic walk_en;
    logic load_ack;
    logic param_wr;
    logic load_param;
    logic emit_en;
    logic burst_clr;
  } ctrl_t;

  typedef struct packed {
    logic clr_done;
    logic walk_done;
    logic frame_ok;
    logic cmd_read;
    logic emit_done;
  } stat_t;

endpackage

@@ rtl/pcfh_ram.sv @@
module pcfh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/pcfh_ctrl.sv @@
module pcfh_ctrl
  import pcfh_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  logic  line_idle,
  input  stat_t stat,
  output ctrl_t ctrl,
  output logic  busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start && line_idle) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (stat.walk_done) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!stat.frame_ok) state_nxt = ST_IDLE;
        else if (stat.cmd_read) state_nxt = ST_PREAD;
        else state_nxt = ST_EMIT;
      end
      ST_PREAD: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.emit_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        ctrl.clr_en = 1'b1;
      end
      ST_IDLE: begin
        busy            = 1'b0;
        ctrl.rx_we      = start && !line_idle;
        ctrl.walk_start = start && line_idle;
      end
      ST_WALK: begin
        ctrl.walk_en = 1'b1;
      end
      ST_CHECK: begin
        ctrl.load_ack  = stat.frame_ok && !stat.cmd_read;
        ctrl.param_wr  = stat.frame_ok && !stat.cmd_read;
        ctrl.burst_clr = !stat.frame_ok;
      end
      ST_PREAD: begin
        ctrl.load_param = 1'b1;
      end
      ST_EMIT: begin
        ctrl.emit_en   = 1'b1;
        ctrl.burst_clr = stat.emit_done;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

@@ rtl/pcfh_datapath.sv @@
module pcfh_datapath
  import pcfh_pkg::*;
#(
  parameter int RX_BUFFER_BYTES = 64,
  parameter int PARAM_ENTRIES   = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_t      ctrl,
  output stat_t      stat,
  input  logic [7:0] rx_byte,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_rst
);

  localparam int AW   = $clog2(RX_BUFFER_BYTES);
  localparam int IW   = AW + 1;
  localparam int CMPW = ((IW > 9) ? IW : 9) + 1;
  localparam int PW   = $clog2(PARAM_ENTRIES);
  localparam logic [CMPW-1:0] BUF_C   = CMPW'(RX_BUFFER_BYTES);
  localparam logic [ID_W:0]   PE_C    = (ID_W + 1)'(PARAM_ENTRIES);
  localparam logic [PW-1:0]   CLR_END = PW'(PARAM_ENTRIES - 1);

  // burst buffer
  logic [IW-1:0] count_r, count_nxt;
  logic          buf_we;
  logic [7:0]    buf_rdata;
  logic [IW-1:0] iss_r, iss_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic          pv_r, pv_nxt;

  // walk state
  logic [7:0] s_r, s_nxt, a_r, a_nxt;
  logic [7:0] h0_r, h0_nxt, tgt_r, tgt_nxt, cmd_r, cmd_nxt, len_r, len_nxt;
  logic       long_r, long_nxt, sok_r, sok_nxt, aok_r, aok_nxt;
  logic [7:0] fld_r [FIELD_BYTES];
  logic [7:0] fld_nxt [FIELD_BYTES];
  logic [7:0] dev_r;

  logic [7:0]      v;
  logic [CMPW-1:0] p_c, len_c;
  logic            long_now;

  // parameter table
  logic [PW-1:0]   clr_idx_r;
  logic [ID_W-1:0] id;
  logic            id_ok;
  logic            prm_we;
  logic [PW-1:0]   prm_waddr;
  logic [31:0]     prm_wdata, prm_rdata, prm_val;

  // response
  logic [7:0] frame_r [FRAME_BYTES];
  logic [7:0] frame_nxt [FRAME_BYTES];
  logic [3:0] flen_r, flen_nxt, eidx_r, eidx_nxt;
  logic       rst_r, rst_nxt;
  logic [7:0] es_r, es_nxt, ea_r, ea_nxt;
  logic [7:0] ebyte;
  logic       elast;
  logic       ov_r, ov_nxt, ol_r, ol_nxt, orq_r, orq_nxt;
  logic [7:0] ob_r, ob_nxt;

  assign buf_we = ctrl.rx_we && (count_r < IW'(RX_BUFFER_BYTES));

  pcfh_ram #(.WIDTH(8), .DEPTH(RX_BUFFER_BYTES)) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (count_r[AW-1:0]),
    .wdata (rx_byte),
    .raddr (iss_r[AW-1:0]),
    .rdata (buf_rdata)
  );

  assign id     = {fld_r[1], fld_r[0]};
  assign id_ok  = {1'b0, id} < PE_C;
  assign prm_we = ctrl.clr_en || (ctrl.param_wr && (cmd_r == CMD_WRITE) && id_ok);
  assign prm_waddr = ctrl.clr_en ? clr_idx_r : id[PW-1:0];
  assign prm_wdata = ctrl.clr_en ? 32'd0 : {fld_r[5], fld_r[4], fld_r[3], fld_r[2]};
  assign prm_val   = id_ok ? prm_rdata : 32'd0;

  pcfh_ram #(.WIDTH(32), .DEPTH(PARAM_ENTRIES)) u_prm (
    .clk   (clk),
    .we    (prm_we),
    .waddr (prm_waddr),
    .wdata (prm_wdata),
    .raddr (id[PW-1:0]),
    .rdata (prm_rdata)
  );

  // bytes not received in this burst read as zero
  assign v        = (pos_r < count_r) ? buf_rdata : 8'd0;
  assign p_c      = CMPW'(pos_r);
  assign len_c    = CMPW'(len_r);
  assign long_now = (CMPW'(v) + CMPW'(5)) >= BUF_C;

  always_comb begin
    count_nxt = count_r;
    if (ctrl.burst_clr) count_nxt = '0;
    else if (buf_we) count_nxt = count_r + IW'(1);
  end

  always_comb begin
    iss_nxt  = iss_r;
    pos_nxt  = pos_r;
    pv_nxt   = pv_r;
    s_nxt    = s_r;
    a_nxt    = a_r;
    h0_nxt   = h0_r;
    tgt_nxt  = tgt_r;
    cmd_nxt  = cmd_r;
    len_nxt  = len_r;
    long_nxt = long_r;
    sok_nxt  = sok_r;
    aok_nxt  = aok_r;
    fld_nxt  = fld_r;
    if (ctrl.walk_start) begin
      iss_nxt  = '0;
      pv_nxt   = 1'b0;
      s_nxt    = 8'd0;
      a_nxt    = 8'd0;
      long_nxt = 1'b0;
      sok_nxt  = 1'b0;
      aok_nxt  = 1'b0;
    end else if (ctrl.walk_en) begin
      iss_nxt = iss_r + IW'(1);
      pos_nxt = iss_r;
      pv_nxt  = 1'b1;
      if (pv_r) begin
        if (p_c < CMPW'(4) || p_c < len_c + CMPW'(4)) begin
          s_nxt = s_r + v;
          a_nxt = a_r + s_r + v;
        end
        if (p_c == CMPW'(0)) h0_nxt = v;
        if (p_c == CMPW'(1)) tgt_nxt = v;
        if (p_c == CMPW'(2)) cmd_nxt = v;
        if (p_c == CMPW'(3)) begin
          len_nxt  = v;
          long_nxt = long_now;
        end
        if (p_c >= CMPW'(4)) begin
          if (p_c == len_c + CMPW'(4)) sok_nxt = (v == s_r);
          if (p_c == len_c + CMPW'(5)) aok_nxt = (v == a_r);
        end
        for (int j = 0; j < FIELD_BYTES; j++) begin
          if (p_c == CMPW'(j + 4)) fld_nxt[j] = v;
        end
      end
    end
  end

  assign stat.walk_done = pv_r &&
    ((p_c == CMPW'(3) && long_now) ||
     (p_c >= CMPW'(9) && p_c >= len_c + CMPW'(5)));
  assign stat.frame_ok = (h0_r == SOF_BYTE) &&
                         (tgt_r == BCAST_ADDR || tgt_r == dev_r) &&
                         (cmd_r == CMD_ACK || cmd_r == CMD_READ || cmd_r == CMD_WRITE) &&
                         !long_r && sok_r && aok_r;
  assign stat.cmd_read = (cmd_r == CMD_READ);
  assign stat.clr_done = (clr_idx_r == CLR_END);

  // response serializer
  assign elast = (eidx_r == flen_r + 4'd1);
  always_comb begin
    if (eidx_r < flen_r) ebyte = frame_r[0];
    else if (eidx_r == flen_r) ebyte = es_r;
    else ebyte = ea_r;
  end
  assign stat.emit_done = elast;

  always_comb begin
    frame_nxt = frame_r;
    flen_nxt  = flen_r;
    eidx_nxt  = eidx_r;
    rst_nxt   = rst_r;
    es_nxt    = es_r;
    ea_nxt    = ea_r;
    ov_nxt    = 1'b0;
    ob_nxt    = ob_r;
    ol_nxt    = 1'b0;
    orq_nxt   = 1'b0;
    if (ctrl.load_ack) begin
      frame_nxt[0] = SOF_BYTE;
      frame_nxt[1] = BCAST_ADDR;
      frame_nxt[2] = ACK_TYPE;
      frame_nxt[3] = ACK_PAY_LEN;
      frame_nxt[4] = cmd_r;
      frame_nxt[5] = s_r;
      frame_nxt[6] = a_r;
      flen_nxt     = ACK_FRAME_LEN;
      rst_nxt      = (cmd_r == CMD_ACK) && (fld_r[0] == SYS_RST_CODE);
      eidx_nxt     = 4'd0;
      es_nxt       = 8'd0;
      ea_nxt       = 8'd0;
    end else if (ctrl.load_param) begin
      frame_nxt[0] = SOF_BYTE;
      frame_nxt[1] = BCAST_ADDR;
      frame_nxt[2] = CMD_WRITE;
      frame_nxt[3] = PARAM_PAY_LEN;
      frame_nxt[4] = fld_r[0];
      frame_nxt[5] = fld_r[1];
      frame_nxt[6] = prm_val[7:0];
      frame_nxt[7] = prm_val[15:8];
      frame_nxt[8] = prm_val[23:16];
      frame_nxt[9] = prm_val[31:24];
      flen_nxt     = PRM_FRAME_LEN;
      rst_nxt      = 1'b0;
      eidx_nxt     = 4'd0;
      es_nxt       = 8'd0;
      ea_nxt       = 8'd0;
    end else if (ctrl.emit_en) begin
      ov_nxt   = 1'b1;
      ob_nxt   = ebyte;
      ol_nxt   = elast;
      orq_nxt  = elast && rst_r;
      eidx_nxt = eidx_r + 4'd1;
      if (eidx_r < flen_r) begin
        es_nxt = es_r + ebyte;
        ea_nxt = ea_r + es_r + ebyte;
        for (int k = 0; k < FRAME_BYTES - 1; k++) begin
          frame_nxt[k] = frame_r[k + 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      pv_r      <= 1'b0;
      clr_idx_r <= '0;
      dev_r     <= DEV_ADDR_RST;
      ov_r      <= 1'b0;
      ol_r      <= 1'b0;
      orq_r     <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pv_r    <= pv_nxt;
      if (ctrl.clr_en) clr_idx_r <= clr_idx_r + PW'(1);
      if (cfg_we) dev_r <= cfg_data;
      ov_r    <= ov_nxt;
      ol_r    <= ol_nxt;
      orq_r   <= orq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r   <= iss_nxt;
    pos_r   <= pos_nxt;
    s_r     <= s_nxt;
    a_r     <= a_nxt;
    h0_r    <= h0_nxt;
    tgt_r   <= tgt_nxt;
    cmd_r   <= cmd_nxt;
    len_r   <= len_nxt;
    long_r  <= long_nxt;
    sok_r   <= sok_nxt;
    aok_r   <= aok_nxt;
    fld_r   <= fld_nxt;
    frame_r <= frame_nxt;
    flen_r  <= flen_nxt;
    eidx_r  <= eidx_nxt;
    rst_r   <= rst_nxt;
    es_r    <= es_nxt;
    ea_r    <= ea_nxt;
    ob_r    <= ob_nxt;
  end

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_last  = ol_r;
  assign out_rst   = orq_r;

endmodule

@@ rtl/param_command_frame_handler.sv @@
// Parameter command frame handler. Pulse start with in_line_idle low to store
// one received byte (busy stays low); a byte past RX_BUFFER_BYTES in a burst
// is dropped. Pulse start with in_line_idle high to close the burst: the
// buffered frame is walked one byte per cycle through the buffer RAM read
// port (the walk stops at the length byte L when L+5 reaches
// RX_BUFFER_BYTES), checked in a check state, and, if valid, answered with a
// 9-byte acknowledge or a 12-byte parameter frame (after a table-read state),
// one word per cycle on out_valid. The receiver cannot stall: each word is
// present for exactly one cycle and must be taken then. busy stays high until
// the last word is on the output. After reset the parameter table is cleared
// one entry per cycle, so busy stays high until every entry is cleared;
// configuration writes are taken meanwhile.
module param_command_frame_handler
  import pcfh_pkg::*;
#(
  parameter int RX_BUFFER_BYTES = 64,
  parameter int PARAM_ENTRIES   = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_rx_byte,
  input  logic       in_line_idle,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_device_address,
  output logic       out_valid,
  output logic [7:0] out_tx_byte,
  output logic       out_last_byte,
  output logic       out_reset_request
);

  `include "assert_macros.svh"

  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready = 1'b1;

  pcfh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .line_idle (in_line_idle),
    .stat      (stat),
    .ctrl      (ctrl),
    .busy      (busy)
  );

  pcfh_datapath #(
    .RX_BUFFER_BYTES (RX_BUFFER_BYTES),
    .PARAM_ENTRIES   (PARAM_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .stat      (stat),
    .rx_byte   (in_rx_byte),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_device_address),
    .out_valid (out_valid),
    .out_byte  (out_tx_byte),
    .out_last  (out_last_byte),
    .out_rst   (out_reset_request)
  );

  `PCFH_ASSERT(a_burst_end_busy, clk, rst_n, (start && !busy && in_line_idle) |=> busy, "burst end did not start processing")
  `PCFH_ASSERT(a_last_valid, clk, rst_n, out_last_byte |-> out_valid, "last byte flag without word")
  `PCFH_ASSERT(a_rst_on_last, clk, rst_n, out_reset_request |-> out_last_byte, "reset request off last byte")
  `PCFH_NEVER(a_emit_then_walk, clk, rst_n, ctrl.emit_en && ctrl.walk_en, "emit and walk overlap")

endmodule
